[rtl/artdmx_universe_store_defines.svh]
// Assertion macros shared by the universe store RTL.
// Each check is clocked on clock and held off while reset is high.
`ifndef ARTDMX_UNIVERSE_STORE_DEFINES_SVH
`define ARTDMX_UNIVERSE_STORE_DEFINES_SVH
`ifndef ASSERT_OFF
// cons must hold in the same cycle as ante
`define ADS_CHECK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("universe store check failed (same cycle)");
// cons must hold in the cycle after ante
`define ADS_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("universe store check failed (next cycle)");
`else
`define ADS_CHECK_NOW(lbl, ante, cons)
`define ADS_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/artdmx_pkg.sv]
package artdmx_pkg;

   localparam int MAX_UNIVERSES  = 4;
   localparam int PACKET_MAX     = 530;
   localparam int SLOT_BYTES     = 512;
   localparam int CHANS_PER_UNIV = 510;
   localparam int HEADER_BYTES   = 18;
   localparam logic [15:0] OPCODE_DMX = 16'h5000;

   // byte count must hold PACKET_MAX itself
   localparam int CNT_W   = $clog2(PACKET_MAX + 1);
   localparam int STG_W   = $clog2(PACKET_MAX);
   localparam int HDR_W   = $clog2(HEADER_BYTES);
   localparam int SLOT_W  = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
   localparam int STORE_W = SLOT_W + 9;
   localparam int STORE_DEPTH = MAX_UNIVERSES * SLOT_BYTES;

   localparam logic [7:0] ID_TEXT [7] = '{8'h41, 8'h72, 8'h74, 8'h2d, 8'h4e, 8'h65, 8'h74};

   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_COLOR   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      CSR_BASE_UNIVERSE  = 3'd0,
      CSR_UNIVERSE_COUNT = 3'd1,
      CSR_PIXEL_COUNT    = 3'd2,
      CSR_PIXEL_START    = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] base_universe;
      logic [2:0]  eff_count;
      logic [15:0] pixel_count;
      logic [15:0] pixel_start;
   } cfg_type;

   // one classified word handed from front to back
   typedef struct packed {
      kind_type          kind;
      logic              ok;
      logic              written;
      logic [7:0]        seq;
      logic [15:0]       universe;
      logic [9:0]        length;
      logic [SLOT_W-1:0] slot;
      logic [9:0]        ncopy;
      logic              pvalid;
      logic [15:0]       chan;
   } entry_type;

   typedef struct packed {
      logic copy_pending;
   } front_status_type;

   typedef struct packed {
      logic copying;
      logic copy_done;
   } back_status_type;

endpackage

[rtl/artdmx_queue.sv]
// Two-entry queue between front and back.
module artdmx_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  artdmx_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output artdmx_pkg::entry_type pop_entry
);

   artdmx_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/artdmx_front.sv]
// Front: takes request words, stages packet bytes, classifies packets and fetches.
module artdmx_front (
   input  logic                         clock,
   input  logic                         reset,
   input  artdmx_pkg::cfg_type          cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,
   input  logic                         req_tlast,
   input  logic                         req_tuser,
   output logic                         push,
   output artdmx_pkg::entry_type        push_entry,
   input  logic                         q_full,
   input  logic [artdmx_pkg::STG_W-1:0] rd_addr,
   output logic [7:0]                   rd_data,
   input  artdmx_pkg::back_status_type  bstat,
   output artdmx_pkg::front_status_type fstat
);

   typedef enum logic [1:0] {
      F_RUN = 2'b01,
      F_FIN = 2'b10
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [artdmx_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic over_ff, over_in;
   logic pend_ff, pend_in;
   logic [7:0] hdr_ff [artdmx_pkg::HEADER_BYTES];
   logic [7:0] stg_ff [artdmx_pkg::PACKET_MAX];
   logic [7:0] rd_data_ff;

   logic        accept, byte_acc, fetch_acc, room;
   logic [7:0]  data_byte;
   logic [15:0] pixel_index;
   logic        id_ok, ok, wr;
   logic [15:0] univ, len_raw, opcode, slot16;
   logic [9:0]  len, ncopy;
   logic [artdmx_pkg::CNT_W-1:0] avail;
   logic [17:0] chan_sum;
   logic [15:0] chan;
   logic [11:0] limit;
   logic        pvalid;

   assign data_byte   = req_tdata[7:0];
   assign pixel_index = req_tdata[23:8];
   assign req_tready  = (state_ff == F_RUN) && !q_full && !pend_ff;
   assign accept      = req_tvalid && req_tready;
   assign byte_acc    = accept && !req_tuser;
   assign fetch_acc   = accept && req_tuser;
   assign room        = (cnt_ff < artdmx_pkg::CNT_W'(artdmx_pkg::PACKET_MAX));
   assign rd_data     = rd_data_ff;
   assign fstat.copy_pending = pend_ff;

   // packet verdict from captured header
   always_comb begin
      id_ok = 1'b1;
      for (int i = 0; i < 7; i++) begin
         if (hdr_ff[i] != artdmx_pkg::ID_TEXT[i]) id_ok = 1'b0;
      end
      opcode  = {hdr_ff[9], hdr_ff[8]};
      univ    = {hdr_ff[15], hdr_ff[14]};
      len_raw = {hdr_ff[16], hdr_ff[17]};
      len     = (len_raw > 16'(artdmx_pkg::SLOT_BYTES)) ? 10'(artdmx_pkg::SLOT_BYTES)
                                                      : len_raw[9:0];
      ok      = !over_ff && (cnt_ff >= artdmx_pkg::CNT_W'(artdmx_pkg::HEADER_BYTES))
                && id_ok && (opcode == artdmx_pkg::OPCODE_DMX);
      slot16  = univ - cfg.base_universe;
      wr      = ok && (slot16 < {13'd0, cfg.eff_count});
      avail   = cnt_ff - artdmx_pkg::CNT_W'(artdmx_pkg::HEADER_BYTES);
      ncopy   = (artdmx_pkg::CNT_W'(len) > avail) ? avail[9:0] : len;
   end

   // fetch channel and range check
   always_comb begin
      chan_sum = {2'b00, cfg.pixel_start} + {1'b0, pixel_index, 1'b0} + {2'b00, pixel_index};
      chan     = chan_sum[15:0];
      limit    = {9'd0, cfg.eff_count} * 12'(artdmx_pkg::CHANS_PER_UNIV);
      pvalid   = (pixel_index < cfg.pixel_count) && (({1'b0, chan} + 17'd2) < {5'd0, limit});
   end

   // queue word build
   always_comb begin
      push_entry.kind     = artdmx_pkg::KIND_VERDICT;
      push_entry.ok       = ok;
      push_entry.written  = wr;
      push_entry.seq      = hdr_ff[12];
      push_entry.universe = univ;
      push_entry.length   = len;
      push_entry.slot     = slot16[artdmx_pkg::SLOT_W-1:0];
      push_entry.ncopy    = ncopy;
      push_entry.pvalid   = pvalid;
      push_entry.chan     = chan;
      push = 1'b0;
      if (state_ff == F_FIN) begin
         push = !q_full;
      end else if (fetch_acc) begin
         push = 1'b1;
         push_entry.kind = artdmx_pkg::KIND_COLOR;
      end
   end

   // control next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      over_in  = over_ff;
      pend_in  = pend_ff;
      if (bstat.copy_done) pend_in = 1'b0;
      case (state_ff)
         F_RUN: begin
            if (byte_acc) begin
               if (room) cnt_in = cnt_ff + 1'b1;
               else over_in = 1'b1;
               if (req_tlast) state_in = F_FIN;
            end
         end
         F_FIN: begin
            if (!q_full) begin
               cnt_in   = '0;
               over_in  = 1'b0;
               state_in = F_RUN;
               if (wr) pend_in = 1'b1;
            end
         end
         default: state_in = F_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_RUN;
         cnt_ff   <= '0;
         over_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         over_ff  <= over_in;
         pend_ff  <= pend_in;
      end
   end

   // header capture
   always_ff @(posedge clock) begin
      if (byte_acc && (cnt_ff < artdmx_pkg::CNT_W'(artdmx_pkg::HEADER_BYTES))) begin
         hdr_ff[cnt_ff[artdmx_pkg::HDR_W-1:0]] <= data_byte;
      end
   end

   // staging memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (byte_acc && room) begin
         stg_ff[cnt_ff[artdmx_pkg::STG_W-1:0]] <= data_byte;
      end
      rd_data_ff <= stg_ff[rd_addr];
   end

endmodule

[rtl/artdmx_back.sv]
// Back: commits slots from staging, serves LED fetches, holds the result word.
module artdmx_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  artdmx_pkg::entry_type        q_entry,
   output logic                         pop,
   output logic [artdmx_pkg::STG_W-1:0] rd_addr,
   input  logic [7:0]                   rd_data,
   output artdmx_pkg::back_status_type  bstat,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [63:0]                  rsp_tdata,
   output logic                         rsp_tuser
);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_COPY = 5'b00010,
      B_DIV  = 5'b00100,
      B_READ = 5'b01000,
      B_OUT  = 5'b10000
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [artdmx_pkg::MAX_UNIVERSES-1:0] written_ff, written_in;
   logic [7:0]  lseq_ff, lseq_in;
   logic [15:0] luniv_ff, luniv_in;
   logic [9:0]  llen_ff, llen_in;
   logic [9:0]  k_ff, k_in;
   logic [1:0]  j_ff, j_in;
   logic [15:0] rem_ff, rem_in;
   logic [artdmx_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [9:0]  ncopy_ff, ncopy_in;
   logic        kind_ff, kind_in, ok_ff, ok_in, wr_ff, wr_in, pv_ff, pv_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [7:0]  store_ff [artdmx_pkg::STORE_DEPTH];
   logic [7:0]  store_rd_ff;
   logic        sv_ff;

   logic        st_we, st_re;
   logic [artdmx_pkg::STORE_W-1:0] st_waddr, st_raddr;
   logic [7:0]  st_wdata, color;
   logic [9:0]  kw;
   logic [10:0] src;

   assign pop        = (state_ff == B_IDLE) && !q_empty;
   assign rsp_tvalid = (state_ff == B_OUT);
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {3'd0, blue_ff, green_ff, red_ff, pv_ff, llen_ff, luniv_ff, lseq_ff,
                        wr_ff, ok_ff};

   // copy addressing: read staging one ahead of the store write
   always_comb begin
      src      = 11'(artdmx_pkg::HEADER_BYTES) + {1'b0, k_ff};
      rd_addr  = src[artdmx_pkg::STG_W-1:0];
      kw       = k_ff - 10'd1;
      st_we    = (state_ff == B_COPY) && (k_ff != 10'd0);
      st_waddr = {slot_ff, kw[8:0]};
      st_wdata = (kw < ncopy_ff) ? rd_data : 8'd0;
      st_re    = (state_ff == B_READ) && (j_ff != 2'd3);
      st_raddr = {slot_ff, rem_ff[8:0]};
      color    = sv_ff ? store_rd_ff : 8'd0;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      written_in = written_ff;
      lseq_in    = lseq_ff;
      luniv_in   = luniv_ff;
      llen_in    = llen_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      rem_in     = rem_ff;
      slot_in    = slot_ff;
      ncopy_in   = ncopy_ff;
      kind_in    = kind_ff;
      ok_in      = ok_ff;
      wr_in      = wr_ff;
      pv_in      = pv_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      bstat.copying   = (state_ff == B_COPY);
      bstat.copy_done = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               kind_in  = q_entry.kind;
               ok_in    = 1'b0;
               wr_in    = 1'b0;
               pv_in    = 1'b0;
               red_in   = 8'd0;
               green_in = 8'd0;
               blue_in  = 8'd0;
               slot_in  = '0;
               if (q_entry.kind == artdmx_pkg::KIND_VERDICT) begin
                  ok_in = q_entry.ok;
                  if (q_entry.ok) begin
                     lseq_in  = q_entry.seq;
                     luniv_in = q_entry.universe;
                     llen_in  = q_entry.length;
                  end
                  if (q_entry.written) begin
                     slot_in  = q_entry.slot;
                     ncopy_in = q_entry.ncopy;
                     k_in     = 10'd0;
                     state_in = B_COPY;
                  end else begin
                     state_in = B_OUT;
                  end
               end else if (q_entry.pvalid) begin
                  pv_in    = 1'b1;
                  rem_in   = q_entry.chan;
                  state_in = B_DIV;
               end else begin
                  state_in = B_OUT;
               end
            end
         end
         B_COPY: begin
            k_in = k_ff + 10'd1;
            if (k_ff == 10'(artdmx_pkg::SLOT_BYTES)) begin
               written_in[slot_ff] = 1'b1;
               wr_in    = 1'b1;
               bstat.copy_done = 1'b1;
               state_in = B_OUT;
            end
         end
         B_DIV: begin
            // one universe subtracted per cycle
            if (rem_ff >= 16'(artdmx_pkg::CHANS_PER_UNIV)) begin
               rem_in  = rem_ff - 16'(artdmx_pkg::CHANS_PER_UNIV);
               slot_in = slot_ff + 1'b1;
            end else begin
               j_in     = 2'd0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            j_in = j_ff + 2'd1;
            if (j_ff != 2'd3) begin
               if (rem_ff == 16'(artdmx_pkg::CHANS_PER_UNIV - 1)) begin
                  rem_in  = 16'd0;
                  slot_in = slot_ff + 1'b1;
               end else begin
                  rem_in = rem_ff + 16'd1;
               end
            end
            case (j_ff)
               2'd1: red_in = color;
               2'd2: green_in = color;
               2'd3: begin
                  blue_in  = color;
                  state_in = B_OUT;
               end
               default: ;
            endcase
         end
         B_OUT: begin
            if (rsp_tready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         written_ff <= '0;
         lseq_ff    <= 8'd0;
         luniv_ff   <= 16'd0;
         llen_ff    <= 10'd0;
      end else begin
         state_ff   <= state_in;
         written_ff <= written_in;
         lseq_ff    <= lseq_in;
         luniv_ff   <= luniv_in;
         llen_ff    <= llen_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      j_ff     <= j_in;
      rem_ff   <= rem_in;
      slot_ff  <= slot_in;
      ncopy_ff <= ncopy_in;
      kind_ff  <= kind_in;
      ok_ff    <= ok_in;
      wr_ff    <= wr_in;
      pv_ff    <= pv_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   // universe store; a slot never committed reads as zero
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_ff[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         store_rd_ff <= store_ff[st_raddr];
         sv_ff       <= written_ff[slot_ff];
      end
   end

endmodule

[rtl/artdmx_universe_store.sv]
// Packet byte: staged when accepted; after the last byte the front classifies the packet.
// Stored packet: byte input stalls until the slot commit is done.
// LED fetch: channel divided by 510 by subtraction, then colors read from the store port.
// Result waits in an output register; up to two words queue behind it.
// Synchronous reset clears control, latest values and slot written bits (no sweep).
module artdmx_universe_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], pixel_index[23:8]
   input  logic        req_tlast,
   input  logic        req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // packet_ok[0], slot_written[1], seq_number[9:2], universe_number[25:10],
   // data_length[35:26], pixel_valid[36], red[44:37], green[52:45], blue[60:53]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser    // result_kind[0]
);

   `include "artdmx_universe_store_defines.svh"

   logic [15:0] base_ff, pcount_ff, pstart_ff;
   logic [2:0]  ucount_ff;
   artdmx_pkg::cfg_type          cfg;
   artdmx_pkg::entry_type        q_push_entry, q_pop_entry;
   artdmx_pkg::front_status_type fstat;
   artdmx_pkg::back_status_type  bstat;
   logic q_push, q_full, q_pop, q_empty;
   logic [artdmx_pkg::STG_W-1:0] stg_addr;
   logic [7:0] stg_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 16'd0;
         ucount_ff <= 3'd1;
         pcount_ff <= 16'd0;
         pstart_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            artdmx_pkg::CSR_BASE_UNIVERSE:  base_ff   <= csr_wdata;
            artdmx_pkg::CSR_UNIVERSE_COUNT: ucount_ff <= csr_wdata[2:0];
            artdmx_pkg::CSR_PIXEL_COUNT:    pcount_ff <= csr_wdata;
            artdmx_pkg::CSR_PIXEL_START:    pstart_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // slot count clipped to store size
   always_comb begin
      cfg.base_universe = base_ff;
      cfg.pixel_count   = pcount_ff;
      cfg.pixel_start   = pstart_ff;
      cfg.eff_count     = ({29'd0, ucount_ff} > artdmx_pkg::MAX_UNIVERSES)
                          ? 3'(artdmx_pkg::MAX_UNIVERSES) : ucount_ff;
   end

   artdmx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push       (q_push),
      .push_entry (q_push_entry),
      .q_full     (q_full),
      .rd_addr    (stg_addr),
      .rd_data    (stg_data),
      .bstat      (bstat),
      .fstat      (fstat)
   );

   artdmx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (q_pop_entry)
   );

   artdmx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (q_pop_entry),
      .pop        (q_pop),
      .rd_addr    (stg_addr),
      .rd_data    (stg_data),
      .bstat      (bstat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // staging must stay frozen while a slot copy runs
   `ADS_CHECK_NOW(a_copy_guarded, bstat.copying, fstat.copy_pending)
   `ADS_CHECK_NOW(a_push_room, q_push, !q_full)
   `ADS_CHECK_NEXT(a_done_release, bstat.copy_done, !fstat.copy_pending)

endmodule
